[rtl/core/flight_phase_sequencer_core_macros.svh]
// Assertion macros for the flight phase sequencer
`ifndef FLIGHT_PHASE_SEQUENCER_CORE_MACROS_SVH
`define FLIGHT_PHASE_SEQUENCER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define FPS_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define FPS_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define FPS_ASSERT_IMP(label, clk, rst_n, a, c)
`define FPS_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

[rtl/core/fps_pkg.sv]
// Package for the flight phase sequencer: types and constants
package fps_pkg;
  localparam int SLOT_COUNT_DEF = 8;
  localparam int CTRL_W = 40;
  localparam int THR_W = 64;
  localparam int ENTRY_W = CTRL_W + THR_W;
  localparam logic [19:0] TICK_MAX = 20'hFFFFF;

  localparam logic [2:0] REG_LAUNCH_VEL = 3'd0;
  localparam logic [2:0] REG_LAUNCH_HOLD = 3'd1;
  localparam logic [2:0] REG_COAST_HOLD = 3'd2;
  localparam logic [2:0] REG_LAND_HOLD = 3'd3;
  localparam logic [2:0] REG_LAND_TIMEOUT = 3'd4;
  localparam logic [2:0] REG_LAND_VEL = 3'd5;
  localparam logic [2:0] REG_LAND_ALT = 3'd6;
  localparam logic [2:0] REG_PAD_PERIOD = 3'd7;

  localparam logic [1:0] COND_NONE = 2'd0;
  localparam logic [1:0] COND_LT = 2'd1;
  localparam logic [1:0] COND_GT = 2'd2;

  typedef enum logic [1:0] {
    PH_WAITING = 2'd0,
    PH_FLIGHT = 2'd1,
    PH_FALLING = 2'd2,
    PH_LANDED = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_OUT
  } seq_state_t;

  typedef struct packed {
    logic [31:0] launch_velocity;
    logic [19:0] launch_hold_ticks;
    logic [19:0] coast_hold_ticks;
    logic [19:0] landing_hold_ticks;
    logic [19:0] landing_timeout_ticks;
    logic [31:0] landing_velocity;
    logic [31:0] landing_altitude;
    logic [15:0] pad_sample_period;
  } cfg_regs_t;

  typedef struct packed {
    logic [1:0] squib;
    logic [1:0] alt_cond;
    logic [1:0] vel_cond;
    logic [1:0] phase;
    logic [31:0] delay;
  } ev_ctrl_t;

  typedef struct packed {
    logic [31:0] alt_thr;
    logic [31:0] vel_thr;
  } ev_thr_t;

  typedef struct packed {
    logic [1:0] phase;
    logic phase_changed;
    logic arm_pyro;
    logic disarm_pyro;
    logic fire;
    logic [1:0] fire_channel;
    logic [3:0] fired_flags;
    logic [31:0] pad_reference;
  } result_t;

  function automatic logic cond_ok(input logic [1:0] code, input logic signed [31:0] v,
                                   input logic signed [31:0] t);
    logic r;
    unique case (code)
      COND_NONE: r = 1'b1;
      COND_LT: r = v < t;
      COND_GT: r = v > t;
      default: r = 1'b0;
    endcase
    return r;
  endfunction
endpackage

[rtl/core/fps_if.sv]
// Valid/ready channel interfaces for sample, result and configuration items
interface fps_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic signed [31:0] velocity;
  logic signed [31:0] altitude;
  logic [31:0] tick_time;
  logic armed;
  logic [2:0] event_index;
  logic [1:0] event_phase;
  logic [1:0] vel_cond;
  logic [1:0] alt_cond;
  logic [1:0] squib;
  modport source (output valid, cmd, velocity, altitude, tick_time, armed, event_index,
                  event_phase, vel_cond, alt_cond, squib, input ready);
  modport sink (input valid, cmd, velocity, altitude, tick_time, armed, event_index,
                event_phase, vel_cond, alt_cond, squib, output ready);
endinterface

interface fps_out_if;
  logic valid;
  logic ready;
  logic [1:0] phase;
  logic phase_changed;
  logic arm_pyro;
  logic disarm_pyro;
  logic fire;
  logic [1:0] fire_channel;
  logic [3:0] fired_flags;
  logic signed [31:0] pad_reference;
  modport source (output valid, phase, phase_changed, arm_pyro, disarm_pyro, fire,
                  fire_channel, fired_flags, pad_reference, input ready);
  modport sink (input valid, phase, phase_changed, arm_pyro, disarm_pyro, fire,
                fire_channel, fired_flags, pad_reference, output ready);
endinterface

interface fps_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/fps_ram.sv]
// Generic single-port-write RAM with registered read
module fps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/fps_cfg.sv]
// Configuration register bank
module fps_cfg (
  input  logic              clk,
  input  logic              rst_n,
  fps_cfg_if.sink           cfg,
  output fps_pkg::cfg_regs_t regs
);
  fps_pkg::cfg_regs_t regs_r;
  assign cfg.ready = 1'b1;
  assign regs = regs_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.launch_velocity <= 32'sd25600;
      regs_r.launch_hold_ticks <= 20'd2000;
      regs_r.coast_hold_ticks <= 20'd500;
      regs_r.landing_hold_ticks <= 20'd30000;
      regs_r.landing_timeout_ticks <= 20'd300000;
      regs_r.landing_velocity <= 32'hFFFFF600;
      regs_r.landing_altitude <= 32'sd25600;
      regs_r.pad_sample_period <= 16'd100;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        fps_pkg::REG_LAUNCH_VEL: regs_r.launch_velocity <= cfg.data;
        fps_pkg::REG_LAUNCH_HOLD: regs_r.launch_hold_ticks <= cfg.data[19:0];
        fps_pkg::REG_COAST_HOLD: regs_r.coast_hold_ticks <= cfg.data[19:0];
        fps_pkg::REG_LAND_HOLD: regs_r.landing_hold_ticks <= cfg.data[19:0];
        fps_pkg::REG_LAND_TIMEOUT: regs_r.landing_timeout_ticks <= cfg.data[19:0];
        fps_pkg::REG_LAND_VEL: regs_r.landing_velocity <= cfg.data;
        fps_pkg::REG_LAND_ALT: regs_r.landing_altitude <= cfg.data;
        fps_pkg::REG_PAD_PERIOD: regs_r.pad_sample_period <= cfg.data[15:0];
        default: ;
      endcase
    end
  end
endmodule

[rtl/core/flight_phase_sequencer_core.sv]
// Flow: a load item goes from idle to the output state; a sample item scans the slots in turn
//   and stops early on a hit. Throughput: one item at a time; the event table RAM read port
//   (each slot is read, then tested) sets the scan length. Result waits in an output register.
// Reset: rst_n synchronous, active low; phase waiting, counters, pad, marks and
//   loaded bits cleared, registers to defaults. Event table RAM contents undefined.
`include "flight_phase_sequencer_core_macros.svh"
module flight_phase_sequencer_core #(
  parameter int SLOT_COUNT = fps_pkg::SLOT_COUNT_DEF
) (
  input logic clk,
  input logic rst_n,
  fps_in_if.sink  in_ch,
  fps_out_if.source out_ch,
  fps_cfg_if.sink cfg_ch
);
  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int RD = (SLOT_COUNT > 1) ? SLOT_COUNT : 2;

  fps_pkg::cfg_regs_t regs;
  fps_cfg u_cfg (.clk(clk), .rst_n(rst_n), .cfg(cfg_ch), .regs(regs));

  fps_pkg::seq_state_t st_r, st_nxt;
  fps_pkg::phase_t phase_r, phase_nxt;
  logic [19:0] ticks_r, ticks_nxt;
  logic [15:0] padcnt_r, padcnt_nxt;
  logic signed [31:0] pad_old_r, pad_old_nxt, pad_new_r, pad_new_nxt;
  logic [31:0] hold_r, hold_nxt;
  logic [SLOT_COUNT-1:0] fired_r, fired_nxt, loaded_r, loaded_nxt;
  logic [3:0] squib_r, squib_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic signed [31:0] vel_r, vel_nxt, agl_r, agl_nxt;
  logic [31:0] ts_r, ts_nxt;
  fps_pkg::result_t res_r, res_nxt;
  logic ov_r, ov_nxt;

  logic we;
  logic [AW-1:0] waddr;
  logic [fps_pkg::ENTRY_W-1:0] wdata, rdata;
  fps_pkg::ev_ctrl_t ec;
  fps_pkg::ev_thr_t et;

  fps_ram #(.WIDTH(fps_pkg::ENTRY_W), .DEPTH(RD)) u_tab (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(idx_r), .rdata(rdata));
  assign {ec, et} = rdata;

  logic signed [32:0] agl_w;
  logic [19:0] tk;
  logic launch, apogee, land, hit, in_range;
  logic [AW:0] last;

  assign in_ch.ready = (st_r == fps_pkg::ST_IDLE) && !ov_r;
  assign out_ch.valid = ov_r;
  assign out_ch.phase = res_r.phase;
  assign out_ch.phase_changed = res_r.phase_changed;
  assign out_ch.arm_pyro = res_r.arm_pyro;
  assign out_ch.disarm_pyro = res_r.disarm_pyro;
  assign out_ch.fire = res_r.fire;
  assign out_ch.fire_channel = res_r.fire_channel;
  assign out_ch.fired_flags = res_r.fired_flags;
  assign out_ch.pad_reference = res_r.pad_reference;

  always_comb begin
    st_nxt = st_r; phase_nxt = phase_r; ticks_nxt = ticks_r; padcnt_nxt = padcnt_r;
    pad_old_nxt = pad_old_r; pad_new_nxt = pad_new_r; hold_nxt = hold_r;
    fired_nxt = fired_r; loaded_nxt = loaded_r; squib_nxt = squib_r; idx_nxt = idx_r;
    vel_nxt = vel_r; agl_nxt = agl_r; ts_nxt = ts_r; res_nxt = res_r; ov_nxt = ov_r;
    we = 1'b0; waddr = AW'(in_ch.event_index);
    wdata = {in_ch.squib, in_ch.alt_cond, in_ch.vel_cond, in_ch.event_phase,
             in_ch.tick_time, in_ch.altitude, in_ch.velocity};
    agl_w = 33'(in_ch.altitude) - 33'(pad_old_r);
    tk = (ticks_r == fps_pkg::TICK_MAX) ? ticks_r : ticks_r + 20'd1;
    launch = 1'b0; apogee = 1'b0; land = 1'b0;
    in_range = ({29'd0, in_ch.event_index} < SLOT_COUNT);
    last = (AW+1)'(SLOT_COUNT - 1);
    hit = loaded_r[idx_r] && !fired_r[idx_r] && (ec.phase == phase_r)
          && fps_pkg::cond_ok(ec.vel_cond, vel_r, et.vel_thr)
          && fps_pkg::cond_ok(ec.alt_cond, agl_r, et.alt_thr) && (ts_r > hold_r);
    if (out_ch.ready) ov_nxt = 1'b0;
    unique case (st_r)
      fps_pkg::ST_IDLE: begin
        if (in_ch.valid && !ov_r) begin
          res_nxt = '0;
          res_nxt.pad_reference = pad_old_r;
          if (in_ch.cmd) begin
            if (in_range) begin
              we = 1'b1;
              loaded_nxt[waddr] = 1'b1;
              fired_nxt[waddr] = 1'b0;
            end
            res_nxt.phase = phase_r;
            res_nxt.fired_flags = squib_r;
            st_nxt = fps_pkg::ST_OUT;
          end else begin
            agl_nxt = (agl_w > 33'sd2147483647) ? 32'sh7FFFFFFF :
                      (agl_w < -33'sd2147483648) ? 32'sh80000000 : agl_w[31:0];
            vel_nxt = in_ch.velocity; ts_nxt = in_ch.tick_time;
            ticks_nxt = tk;
            unique case (phase_r)
              fps_pkg::PH_WAITING: begin
                launch = (tk > regs.launch_hold_ticks) && in_ch.armed
                         && (in_ch.velocity > $signed(regs.launch_velocity));
                if (launch) begin
                  phase_nxt = fps_pkg::PH_FLIGHT; ticks_nxt = '0;
                  res_nxt.arm_pyro = 1'b1;
                end else begin
                  padcnt_nxt = padcnt_r + 16'd1;
                  if (padcnt_nxt >= regs.pad_sample_period) begin
                    padcnt_nxt = '0; pad_old_nxt = pad_new_r; pad_new_nxt = in_ch.altitude;
                  end
                end
              end
              fps_pkg::PH_FLIGHT: begin
                apogee = (tk > regs.coast_hold_ticks) && in_ch.velocity[31];
                if (apogee) begin
                  phase_nxt = fps_pkg::PH_FALLING; ticks_nxt = '0;
                end
              end
              fps_pkg::PH_FALLING: begin
                land = ((tk > regs.landing_hold_ticks)
                        && (in_ch.velocity > $signed(regs.landing_velocity))
                        && ($signed(agl_nxt) < $signed(regs.landing_altitude)))
                       || (tk > regs.landing_timeout_ticks);
                if (land) begin
                  phase_nxt = fps_pkg::PH_LANDED; ticks_nxt = '0;
                  res_nxt.disarm_pyro = 1'b1;
                end
              end
              default: ;
            endcase
            res_nxt.phase_changed = launch || apogee || land;
            idx_nxt = '0;
            st_nxt = fps_pkg::ST_SCAN;
          end
        end
      end
      fps_pkg::ST_SCAN: st_nxt = fps_pkg::ST_CHECK;
      fps_pkg::ST_CHECK: begin
        if (hit) begin
          fired_nxt[idx_r] = 1'b1;
          hold_nxt = ts_r + ec.delay;
          squib_nxt = squib_r | (4'd1 << ec.squib);
          res_nxt.fire = 1'b1;
          res_nxt.fire_channel = ec.squib;
          st_nxt = fps_pkg::ST_OUT;
        end else if ({1'b0, idx_r} == last) begin
          st_nxt = fps_pkg::ST_OUT;
        end else begin
          idx_nxt = idx_r + AW'(1);
          st_nxt = fps_pkg::ST_SCAN;
        end
      end
      fps_pkg::ST_OUT: begin
        res_nxt.phase = phase_r;
        res_nxt.fired_flags = squib_r;
        ov_nxt = 1'b1;
        st_nxt = fps_pkg::ST_IDLE;
      end
      default: st_nxt = fps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= fps_pkg::ST_IDLE; phase_r <= fps_pkg::PH_WAITING; ticks_r <= '0;
      padcnt_r <= '0; pad_old_r <= '0; pad_new_r <= '0; hold_r <= '0;
      fired_r <= '0; loaded_r <= '0; squib_r <= '0; ov_r <= 1'b0; idx_r <= '0;
    end else begin
      st_r <= st_nxt; phase_r <= phase_nxt; ticks_r <= ticks_nxt; padcnt_r <= padcnt_nxt;
      pad_old_r <= pad_old_nxt; pad_new_r <= pad_new_nxt; hold_r <= hold_nxt;
      fired_r <= fired_nxt; loaded_r <= loaded_nxt; squib_r <= squib_nxt;
      ov_r <= ov_nxt; idx_r <= idx_nxt;
    end
    vel_r <= vel_nxt; agl_r <= agl_nxt; ts_r <= ts_nxt; res_r <= res_nxt;
  end

  `FPS_ASSERT_IMP(a_fire_once, clk, rst_n, st_r == fps_pkg::ST_CHECK && hit, !fired_r[idx_r])
  `FPS_ASSERT_NXT(a_fire_flag, clk, rst_n, st_r == fps_pkg::ST_CHECK && hit, squib_r != 4'd0)
  `FPS_ASSERT_IMP(a_busy, clk, rst_n, st_r != fps_pkg::ST_IDLE, !in_ch.ready)
  `FPS_ASSERT_NXT(a_out_set, clk, rst_n, st_r == fps_pkg::ST_OUT, ov_r)
endmodule
